// ===== sv/awrps_pkg.sv =====
// Package for the age/weight ratio priority selector.
// Holds action and status codes, the controller state type and command structs.
`default_nettype none
package awrps_pkg;
  localparam int unsigned ActW  = 2;
  localparam int unsigned IdW   = 32;
  localparam int unsigned AgeW  = 16;
  localparam int unsigned WtW   = 16;
  localparam int unsigned KindW = 3;
  localparam int unsigned RatW  = 16;
  localparam int unsigned BalW  = 18;
  localparam int unsigned StW   = 2;

  localparam logic [ActW-1:0] ActInsert = 2'd0;
  localparam logic [ActW-1:0] ActRemove = 2'd1;
  localparam logic [ActW-1:0] ActPop    = 2'd2;
  // Spare code: the request changes nothing and reports ok.
  localparam logic [ActW-1:0] ActNone   = 2'd3;

  localparam logic [StW-1:0] StOk       = 2'd0;
  localparam logic [StW-1:0] StEmpty    = 2'd1;
  localparam logic [StW-1:0] StFull     = 2'd2;
  localparam logic [StW-1:0] StNotFound = 2'd3;

  localparam logic CfgAgeRatio    = 1'b0;
  localparam logic CfgWeightRatio = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_WAIT, S_FINISH, S_OUT
  } state_e;

  typedef struct packed {
    logic start;   // load request and clear scan pointer
    logic step;    // issue read of next slot
    logic finish;  // commit result
  } cmd_t;

  typedef struct packed {
    logic last;    // last slot address has been issued
  } sts_t;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [AgeW-1:0]  age;
    logic [WtW-1:0]   weight;
    logic [KindW-1:0] kind;
  } entry_t;
endpackage
`default_nettype wire

// ===== sv/age_weight_ratio_priority_selector.sv =====
// Top level of the age/weight ratio priority selector.
// Depends on awrps_pkg, awrps_ctrl and awrps_dp.
`default_nettype none
// Holds up to CAPACITY entries and serves insert, remove-by-id and pop requests,
// one result beat for each request beat. For every request one comparator walks
// the entry memory, one slot per cycle through its single registered read port,
// then a wait state and a commit state follow. The next request is accepted in
// the cycle its predecessor's result is taken. The user must write configuration
// registers only while the block is idle; the block itself does not enforce this.
module age_weight_ratio_priority_selector #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [31:0] entry_id_i,
  input  wire logic [15:0] entry_age_i,
  input  wire logic [15:0] entry_weight_i,
  input  wire logic [2:0]  entry_kind_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [31:0]      picked_id_o,
  output logic [15:0]      picked_age_o,
  output logic [15:0]      picked_weight_o,
  output logic             picked_by_weight_o,
  output logic [$clog2(CAPACITY+1)-1:0] occupancy_o
);
  awrps_pkg::cmd_t cmd;
  awrps_pkg::sts_t sts;
  awrps_pkg::entry_t ent;

  assign ent.id = entry_id_i;
  assign ent.age = entry_age_i;
  assign ent.weight = entry_weight_i;
  assign ent.kind = entry_kind_i;

  awrps_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  awrps_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .action_i, .entry_i(ent), .status_o, .picked_id_o, .picked_age_o,
    .picked_weight_o, .picked_by_weight_o, .occupancy_o
  );
endmodule
`default_nettype wire

// ===== sv/awrps_ctrl.sv =====
// Controller for the selector: sequences one scan over all slots per request.
// Depends on awrps_pkg.
`default_nettype none
module awrps_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  input  wire awrps_pkg::sts_t sts_i,
  output awrps_pkg::cmd_t      cmd_o
);
  awrps_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= awrps_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      awrps_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d = awrps_pkg::S_SCAN;
        end
      end
      awrps_pkg::S_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.last) state_d = awrps_pkg::S_WAIT;
      end
      awrps_pkg::S_WAIT: state_d = awrps_pkg::S_FINISH;
      awrps_pkg::S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d = awrps_pkg::S_OUT;
      end
      awrps_pkg::S_OUT: begin
        out_valid_o = 1'b1;
        in_stall_o  = out_stall_i;
        if (!out_stall_i) begin
          if (in_valid_i) begin
            cmd_o.start = 1'b1;
            state_d = awrps_pkg::S_SCAN;
          end else begin
            state_d = awrps_pkg::S_IDLE;
          end
        end
      end
      default: state_d = awrps_pkg::S_IDLE;
    endcase
  end

  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == awrps_pkg::S_OUT) else $error("valid outside output state");
  a_finish_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_o) else $error("result not shown after finish");
  a_start_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> state_q == awrps_pkg::S_SCAN) else $error("start did not scan");
endmodule
`default_nettype wire

// ===== sv/awrps_dp.sv =====
// Datapath for the selector: entry memory, valid bits, scan comparator, balance.
// Depends on awrps_pkg.
`default_nettype none
module awrps_dp #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire awrps_pkg::cmd_t             cmd_i,
  output awrps_pkg::sts_t                  sts_o,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_idx_i,
  input  wire logic [awrps_pkg::RatW-1:0]  cfg_data_i,
  input  wire logic [awrps_pkg::ActW-1:0]  action_i,
  input  wire awrps_pkg::entry_t           entry_i,
  output logic [awrps_pkg::StW-1:0]        status_o,
  output logic [awrps_pkg::IdW-1:0]        picked_id_o,
  output logic [awrps_pkg::AgeW-1:0]       picked_age_o,
  output logic [awrps_pkg::WtW-1:0]        picked_weight_o,
  output logic                             picked_by_weight_o,
  output logic [CW-1:0]                    occupancy_o
);
  awrps_pkg::entry_t mem [CAPACITY];
  awrps_pkg::entry_t rd_q;
  logic [CAPACITY-1:0] vld_q;
  logic [AW-1:0] ptr_q, rd_addr_q, best_q;
  logic rd_ok_q, found_q, bw_q;
  awrps_pkg::entry_t best_e_q, req_q;
  logic [awrps_pkg::ActW-1:0] act_q;
  logic [awrps_pkg::RatW-1:0] ar_q, wr_q;
  logic signed [awrps_pkg::BalW-1:0] bal_q;
  logic [CW-1:0] cnt_q;

  assign sts_o.last = (ptr_q == AW'(CAPACITY - 1));

  // Memory read and write.
  always_ff @(posedge clk_i) begin
    rd_q <= mem[ptr_q];
    if (cmd_i.finish && act_q == awrps_pkg::ActInsert && found_q) mem[best_q] <= req_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ar_q <= awrps_pkg::RatW'(1);
      wr_q <= awrps_pkg::RatW'(1);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == awrps_pkg::CfgAgeRatio) ar_q <= cfg_data_i;
      else wr_q <= cfg_data_i;
    end
  end

  // Candidate precedence against the current best.
  logic [awrps_pkg::AgeW-1:0] ca1, cb1, ca2, cb2;
  logic better, is_match;
  always_comb begin
    ca1 = bw_q ? rd_q.weight : rd_q.age;
    cb1 = bw_q ? best_e_q.weight : best_e_q.age;
    ca2 = bw_q ? rd_q.age : rd_q.weight;
    cb2 = bw_q ? best_e_q.age : best_e_q.weight;
    if (ca1 != cb1) better = ca1 < cb1;
    else if (ca2 != cb2) better = ca2 < cb2;
    else if (rd_q.kind != best_e_q.kind) better = rd_q.kind > best_e_q.kind;
    else better = rd_q.id < best_e_q.id;
    is_match = rd_q.id == req_q.id;
  end

  logic slot_v;
  assign slot_v = vld_q[rd_addr_q];

  // A pop that found an entry reports it; every other request reports zeros.
  logic pop_hit;
  assign pop_hit = (act_q == awrps_pkg::ActPop) && found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0; ptr_q <= '0; rd_addr_q <= '0; rd_ok_q <= 1'b0;
      found_q <= 1'b0; bw_q <= 1'b0; bal_q <= '0; cnt_q <= '0;
      act_q <= awrps_pkg::ActInsert; best_q <= '0;
      status_o <= awrps_pkg::StOk; picked_id_o <= '0; picked_age_o <= '0;
      picked_weight_o <= '0; picked_by_weight_o <= 1'b0;
    end else begin
      rd_addr_q <= ptr_q;
      rd_ok_q   <= cmd_i.step;
      if (cmd_i.start) begin
        ptr_q   <= '0;
        found_q <= 1'b0;
        act_q   <= action_i;
        if (bal_q > 0) bw_q <= 1'b1;
        else if (bal_q < 0) bw_q <= 1'b0;
        else bw_q <= ar_q <= wr_q;
      end else if (cmd_i.step && !sts_o.last) begin
        ptr_q <= ptr_q + AW'(1);
      end
      if (rd_ok_q) begin
        case (act_q)
          awrps_pkg::ActInsert:
            if (!slot_v && !found_q) begin found_q <= 1'b1; best_q <= rd_addr_q; end
          awrps_pkg::ActRemove:
            if (slot_v && !found_q && is_match) begin
              found_q <= 1'b1; best_q <= rd_addr_q;
            end
          awrps_pkg::ActPop:
            if (slot_v && (!found_q || better)) begin
              found_q <= 1'b1; best_q <= rd_addr_q;
            end
          default: ;
        endcase
      end
      if (cmd_i.finish) begin
        picked_id_o        <= pop_hit ? best_e_q.id : '0;
        picked_age_o       <= pop_hit ? best_e_q.age : '0;
        picked_weight_o    <= pop_hit ? best_e_q.weight : '0;
        picked_by_weight_o <= pop_hit && bw_q;
        case (act_q)
          awrps_pkg::ActInsert: begin
            status_o <= found_q ? awrps_pkg::StOk : awrps_pkg::StFull;
            if (found_q) begin vld_q[best_q] <= 1'b1; cnt_q <= cnt_q + CW'(1); end
          end
          awrps_pkg::ActRemove: begin
            status_o <= found_q ? awrps_pkg::StOk : awrps_pkg::StNotFound;
            if (found_q) begin vld_q[best_q] <= 1'b0; cnt_q <= cnt_q - CW'(1); end
          end
          awrps_pkg::ActPop: begin
            status_o <= found_q ? awrps_pkg::StOk : awrps_pkg::StEmpty;
            if (found_q) begin
              vld_q[best_q] <= 1'b0; cnt_q <= cnt_q - CW'(1);
              if (bw_q) bal_q <= bal_q - $signed({2'b00, ar_q});
              else bal_q <= bal_q + $signed({2'b00, wr_q});
            end
          end
          default: status_o <= awrps_pkg::StOk;
        endcase
      end
    end
  end

  // Payload registers: request and best candidate.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) req_q <= entry_i;
    if (rd_ok_q && act_q == awrps_pkg::ActPop && slot_v && (!found_q || better))
      best_e_q <= rd_q;
  end

  assign occupancy_o = cnt_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY)) else $error("occupancy overflow");
  a_cnt_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == CW'($countones(vld_q))) else $error("count and valid bits disagree");
  a_fin_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> !cmd_i.finish) else $error("double commit");
endmodule
`default_nettype wire
